@@ sv/bbg_pkg.sv @@
// Shared types, constants and helpers of the brownout backlight governor.
package bbg_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_CONFIRM    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_STOP_DELAY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP           = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_NORMAL        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DIMMED        = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CRITICAL      = 4'd7;

    localparam logic [15:0] RST_SAMPLE_INTERVAL     = 16'd100;
    localparam logic [15:0] RST_RECOVERY_CONFIRM    = 16'd5000;
    localparam logic [15:0] RST_CRITICAL_STOP_DELAY = 16'd5000;
    localparam logic [7:0]  RST_RAMP_INTERVAL       = 8'd20;
    localparam logic [7:0]  RST_RAMP_STEP           = 8'd10;
    localparam logic [7:0]  RST_LEVEL_NORMAL        = 8'd255;
    localparam logic [7:0]  RST_LEVEL_DIMMED        = 8'd128;
    localparam logic [7:0]  RST_LEVEL_CRITICAL      = 8'd26;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_DIMMED   = 2'd1,
        LVL_CRITICAL = 2'd2
    } t_level;

    typedef struct packed {
        logic [15:0] sample_interval;
        logic [15:0] recovery_confirm;
        logic [15:0] critical_stop_delay;
        logic [7:0]  ramp_interval;
        logic [7:0]  ramp_step;
        logic [7:0]  level_normal;
        logic [7:0]  level_dimmed;
        logic [7:0]  level_critical;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        below_dimmed;
        logic        below_critical;
        logic        ramp_hold;
        logic        governor_enable;
    } t_item;

    typedef struct packed {
        logic [7:0] brightness;
        logic [1:0] supply_level;
        logic       low_battery;
        logic       enter_low_event;
        logic       leave_low_event;
        logic       sleep_request;
    } t_result;

    function automatic logic [7:0] level_brightness(t_level lvl, t_cfg cfg);
        logic [7:0] b;
        case (lvl)
            LVL_CRITICAL: b = cfg.level_critical;
            LVL_DIMMED:   b = cfg.level_dimmed;
            default:      b = cfg.level_normal;
        endcase
        return b;
    endfunction

endpackage

@@ sv/bbg_in_if.sv @@
// Input channel: one millisecond tick per beat.
interface bbg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        below_dimmed;
    logic        below_critical;
    logic        ramp_hold;
    logic        governor_enable;

    modport source (output valid, now_ms, below_dimmed, below_critical, ramp_hold,
                    governor_enable, input ready);
    modport sink   (input valid, now_ms, below_dimmed, below_critical, ramp_hold,
                    governor_enable, output ready);
endinterface

@@ sv/bbg_out_if.sv @@
// Output channel: one governor result per beat.
interface bbg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] brightness;
    logic [1:0] supply_level;
    logic       low_battery;
    logic       enter_low_event;
    logic       leave_low_event;
    logic       sleep_request;

    modport source (output valid, brightness, supply_level, low_battery, enter_low_event,
                    leave_low_event, sleep_request, input ready);
    modport sink   (input valid, brightness, supply_level, low_battery, enter_low_event,
                    leave_low_event, sleep_request, output ready);
endinterface

@@ sv/bbg_cfg_regs.sv @@
// Configuration register file of the governor with its reset values.
module bbg_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bbg_pkg::t_cfg                 o_cfg
);

    bbg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval     <= bbg_pkg::RST_SAMPLE_INTERVAL;
            r_cfg.recovery_confirm    <= bbg_pkg::RST_RECOVERY_CONFIRM;
            r_cfg.critical_stop_delay <= bbg_pkg::RST_CRITICAL_STOP_DELAY;
            r_cfg.ramp_interval       <= bbg_pkg::RST_RAMP_INTERVAL;
            r_cfg.ramp_step           <= bbg_pkg::RST_RAMP_STEP;
            r_cfg.level_normal        <= bbg_pkg::RST_LEVEL_NORMAL;
            r_cfg.level_dimmed        <= bbg_pkg::RST_LEVEL_DIMMED;
            r_cfg.level_critical      <= bbg_pkg::RST_LEVEL_CRITICAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bbg_pkg::CFG_SAMPLE_INTERVAL:     r_cfg.sample_interval     <= i_cfg_data;
                bbg_pkg::CFG_RECOVERY_CONFIRM:    r_cfg.recovery_confirm    <= i_cfg_data;
                bbg_pkg::CFG_CRITICAL_STOP_DELAY: r_cfg.critical_stop_delay <= i_cfg_data;
                bbg_pkg::CFG_RAMP_INTERVAL:       r_cfg.ramp_interval  <= i_cfg_data[7:0];
                bbg_pkg::CFG_RAMP_STEP:           r_cfg.ramp_step      <= i_cfg_data[7:0];
                bbg_pkg::CFG_LEVEL_NORMAL:        r_cfg.level_normal   <= i_cfg_data[7:0];
                bbg_pkg::CFG_LEVEL_DIMMED:        r_cfg.level_dimmed   <= i_cfg_data[7:0];
                bbg_pkg::CFG_LEVEL_CRITICAL:      r_cfg.level_critical <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/bbg_gov_core.sv @@
// Governor state and the single-pass update that one tick applies to it.
module bbg_gov_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  bbg_pkg::t_cfg    i_cfg,
    input  bbg_pkg::t_item   i_item,
    output bbg_pkg::t_result o_res
);

    logic [31:0]     r_last_sample, n_last_sample;
    logic [31:0]     r_recovery_start, n_recovery_start;
    logic [31:0]     r_critical_start, n_critical_start;
    logic [31:0]     r_last_ramp, n_last_ramp;
    bbg_pkg::t_level r_applied, n_applied;
    bbg_pkg::t_level r_measured, n_measured;
    logic            r_low_mode, n_low_mode;
    logic [7:0]      r_cur, n_cur;
    logic [7:0]      r_tgt, n_tgt;

    logic [7:0]      cur_ramped;
    logic [7:0]      ramp_rem;
    logic            ramp_go;
    logic            sample_go;
    bbg_pkg::t_level meas_lvl;
    bbg_pkg::t_level next_lvl;
    logic            do_apply;
    logic            ev_enter;
    logic            ev_leave;
    logic            sleep_req;

    always_comb begin
        n_last_sample    = r_last_sample;
        n_recovery_start = r_recovery_start;
        n_critical_start = r_critical_start;
        n_last_ramp      = r_last_ramp;
        n_applied        = r_applied;
        n_measured       = r_measured;
        n_low_mode       = r_low_mode;
        n_tgt            = r_tgt;
        do_apply         = 1'b0;
        next_lvl         = r_applied;
        ev_enter         = 1'b0;
        ev_leave         = 1'b0;

        ramp_go = !i_item.ramp_hold && (r_cur < r_tgt) &&
                  ((i_item.now_ms - r_last_ramp) >= {24'd0, i_cfg.ramp_interval});
        ramp_rem = r_tgt - r_cur;
        cur_ramped = r_cur;
        if (ramp_go) begin
            n_last_ramp = i_item.now_ms;
            cur_ramped  = r_cur + ((ramp_rem > i_cfg.ramp_step) ? i_cfg.ramp_step : ramp_rem);
        end
        n_cur = cur_ramped;

        if (i_item.below_critical) begin
            meas_lvl = bbg_pkg::LVL_CRITICAL;
        end else if (i_item.below_dimmed) begin
            meas_lvl = bbg_pkg::LVL_DIMMED;
        end else begin
            meas_lvl = bbg_pkg::LVL_NORMAL;
        end

        sample_go = i_item.governor_enable &&
                    ((i_item.now_ms - r_last_sample) >= {16'd0, i_cfg.sample_interval});

        if (sample_go) begin
            n_last_sample = i_item.now_ms;
            n_measured    = meas_lvl;
            if (meas_lvl == bbg_pkg::LVL_CRITICAL) begin
                if (r_critical_start == 32'd0) begin
                    n_critical_start = i_item.now_ms;
                end
            end else begin
                n_critical_start = 32'd0;
            end

            if (meas_lvl > r_applied) begin
                n_recovery_start = 32'd0;
                do_apply         = 1'b1;
                next_lvl         = meas_lvl;
            end else if (meas_lvl < r_applied) begin
                if (r_recovery_start == 32'd0) begin
                    n_recovery_start = i_item.now_ms;
                end else if ((i_item.now_ms - r_recovery_start) >=
                             {16'd0, i_cfg.recovery_confirm}) begin
                    do_apply         = 1'b1;
                    next_lvl         = bbg_pkg::t_level'(r_applied - 2'd1);
                    n_recovery_start = i_item.now_ms;
                end
            end else begin
                n_recovery_start = 32'd0;
            end
        end

        // A new target only lowers the current duty; a higher one is reached by the ramp.
        if (do_apply) begin
            n_applied = next_lvl;
            n_tgt     = bbg_pkg::level_brightness(next_lvl, i_cfg);
            if (n_tgt <= cur_ramped) begin
                n_cur = n_tgt;
            end
            if (next_lvl == bbg_pkg::LVL_CRITICAL) begin
                if (!r_low_mode) begin
                    n_low_mode = 1'b1;
                    ev_enter   = 1'b1;
                end
            end else if (r_applied == bbg_pkg::LVL_CRITICAL) begin
                n_low_mode = 1'b0;
                ev_leave   = 1'b1;
            end
        end

        sleep_req = i_item.governor_enable && n_low_mode &&
                    (n_measured == bbg_pkg::LVL_CRITICAL) && (n_critical_start != 32'd0) &&
                    ((i_item.now_ms - n_critical_start) >= {16'd0, i_cfg.critical_stop_delay});

        o_res.brightness      = n_cur;
        o_res.supply_level    = n_applied;
        o_res.low_battery     = n_low_mode;
        o_res.enter_low_event = ev_enter;
        o_res.leave_low_event = ev_leave;
        o_res.sleep_request   = sleep_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample    <= 32'd0;
            r_recovery_start <= 32'd0;
            r_critical_start <= 32'd0;
            r_last_ramp      <= 32'd0;
            r_applied        <= bbg_pkg::LVL_NORMAL;
            r_measured       <= bbg_pkg::LVL_NORMAL;
            r_low_mode       <= 1'b0;
            r_cur            <= 8'd0;
            r_tgt            <= 8'd0;
        end else if (i_step) begin
            r_last_sample    <= n_last_sample;
            r_recovery_start <= n_recovery_start;
            r_critical_start <= n_critical_start;
            r_last_ramp      <= n_last_ramp;
            r_applied        <= n_applied;
            r_measured       <= n_measured;
            r_low_mode       <= n_low_mode;
            r_cur            <= n_cur;
            r_tgt            <= n_tgt;
        end
    end

endmodule

@@ sv/brownout_backlight_governor_unit.sv @@
// Top level of the brownout backlight governor.
// Each beat on i_in is one millisecond tick: the free-running time, the two
// supply comparator bits, the ramp hold and the governor enable. Each tick
// gives exactly one beat on o_out with the backlight duty, the applied supply
// level, the low-battery flag, its enter and leave events and the sleep request.
// A tick is first captured in an input register; once the output register is free
// or being read, the governor state is updated and the result is loaded into the
// output register. One tick is accepted every cycle while the receiver keeps up.
// When the receiver stalls, the result waits in the output register and one more
// tick is still taken into the input register; only then does i_in.ready drop.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them only while the channels are idle, which the block does
// not enforce; indexes beyond the list are ignored. Reset restores the register
// defaults, clears the governor state to the normal level with zero duty and
// empties both registers.
module brownout_backlight_governor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbg_in_if.sink                        i_in,
    bbg_out_if.source                     o_out
);

    bbg_pkg::t_cfg    cfg;
    bbg_pkg::t_result res;
    bbg_pkg::t_item   r_item;
    bbg_pkg::t_result r_res;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             out_load;
    logic             in_take;

    assign out_load   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || out_load;
    assign in_take    = i_in.valid && i_in.ready;

    bbg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bbg_gov_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (out_load),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.now_ms          <= i_in.now_ms;
            r_item.below_dimmed    <= i_in.below_dimmed;
            r_item.below_critical  <= i_in.below_critical;
            r_item.ramp_hold       <= i_in.ramp_hold;
            r_item.governor_enable <= i_in.governor_enable;
        end
        if (out_load) begin
            r_res <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.brightness      = r_res.brightness;
    assign o_out.supply_level    = r_res.supply_level;
    assign o_out.low_battery     = r_res.low_battery;
    assign o_out.enter_low_event = r_res.enter_low_event;
    assign o_out.leave_low_event = r_res.leave_low_event;
    assign o_out.sleep_request   = r_res.sleep_request;

endmodule

@@ sv/bbg_props.sv @@
// Port-level assertions of the governor and their binding to the top level.
module bbg_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_brightness,
    input logic [1:0] i_supply_level,
    input logic       i_low_battery,
    input logic       i_enter_low_event,
    input logic       i_leave_low_event,
    input logic       i_sleep_request
);

    a_low_tracks_critical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_low_battery ==
                         (i_supply_level == bbg_pkg::LVL_CRITICAL)))
        else $error("low-battery flag disagrees with the applied level");

    a_enter_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_enter_low_event) |-> (i_low_battery && !i_leave_low_event))
        else $error("enter event without low-battery mode");

    a_leave_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_leave_low_event) |-> (!i_low_battery &&
            (i_supply_level == bbg_pkg::LVL_DIMMED)))
        else $error("leave event must step down to the dimmed level");

    a_sleep_needs_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sleep_request) |-> i_low_battery)
        else $error("sleep request outside low-battery mode");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_brightness) &&
            $stable(i_supply_level) && $stable(i_sleep_request)))
        else $error("stalled output beat changed");

endmodule

bind brownout_backlight_governor_unit bbg_props u_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_brightness      (o_out.brightness),
    .i_supply_level    (o_out.supply_level),
    .i_low_battery     (o_out.low_battery),
    .i_enter_low_event (o_out.enter_low_event),
    .i_leave_low_event (o_out.leave_low_event),
    .i_sleep_request   (o_out.sleep_request)
);

@@ dv/bbg_result_compare.sv @@
`timescale 1ns / 100ps
// Predicts each governor result from the accepted tick beats and compares it with the output beats.
module bbg_result_compare
    import bbg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bbg_in_if                     i_in,
    bbg_out_if                    i_out,
    output int                    o_pending,
    output int                    o_mismatches,
    output int                    o_checked
);

    t_cfg        regs;
    logic [31:0] sample_at;
    logic [31:0] recover_since;
    logic [31:0] critical_since;
    logic [31:0] ramp_at;
    t_level      lvl_applied;
    t_level      lvl_measured;
    logic        low_mode;
    logic [7:0]  duty;
    logic [7:0]  duty_goal;
    logic        ev_enter;
    logic        ev_leave;
    t_result     expected_results [$];
    int          mismatches;
    int          checked;

    function automatic void clear_model();
        regs.sample_interval     = RST_SAMPLE_INTERVAL;
        regs.recovery_confirm    = RST_RECOVERY_CONFIRM;
        regs.critical_stop_delay = RST_CRITICAL_STOP_DELAY;
        regs.ramp_interval       = RST_RAMP_INTERVAL;
        regs.ramp_step           = RST_RAMP_STEP;
        regs.level_normal        = RST_LEVEL_NORMAL;
        regs.level_dimmed        = RST_LEVEL_DIMMED;
        regs.level_critical      = RST_LEVEL_CRITICAL;
        sample_at      = '0;
        recover_since  = '0;
        critical_since = '0;
        ramp_at        = '0;
        lvl_applied    = LVL_NORMAL;
        lvl_measured   = LVL_NORMAL;
        low_mode       = 1'b0;
        duty           = '0;
        duty_goal      = '0;
        ev_enter       = 1'b0;
        ev_leave       = 1'b0;
    endfunction

    function automatic logic [7:0] duty_for(t_level lvl);
        logic [7:0] d;
        case (lvl)
            LVL_CRITICAL: d = regs.level_critical;
            LVL_DIMMED:   d = regs.level_dimmed;
            default:      d = regs.level_normal;
        endcase
        return d;
    endfunction

    function automatic void aim_duty(logic [7:0] d);
        duty_goal = d;
        if (duty_goal <= duty) begin
            duty = duty_goal;
        end
    endfunction

    function automatic void change_level(t_level next, logic hold);
        t_level prev;
        prev = lvl_applied;
        if (prev != next) begin
            lvl_applied = next;
            aim_duty(duty_for(next));
            if (next == LVL_CRITICAL) begin
                if (!low_mode) begin
                    low_mode = 1'b1;
                    ev_enter = 1'b1;
                    aim_duty(regs.level_critical);
                end
            end else if (prev == LVL_CRITICAL) begin
                low_mode = 1'b0;
                ev_leave = 1'b1;
                if (!hold) begin
                    aim_duty(duty_for(lvl_applied));
                end
            end
        end
    endfunction

    function automatic t_result govern_tick(t_item it);
        t_result    r;
        logic [7:0] gap;
        logic       sleep;
        ev_enter = 1'b0;
        ev_leave = 1'b0;
        sleep    = 1'b0;
        if (!it.ramp_hold && duty < duty_goal &&
            (it.now_ms - ramp_at) >= {24'd0, regs.ramp_interval}) begin
            ramp_at = it.now_ms;
            gap     = duty_goal - duty;
            duty    = duty + ((gap > regs.ramp_step) ? regs.ramp_step : gap);
        end
        if (it.governor_enable) begin
            if ((it.now_ms - sample_at) >= {16'd0, regs.sample_interval}) begin
                sample_at = it.now_ms;
                lvl_measured = it.below_critical ? LVL_CRITICAL :
                               it.below_dimmed   ? LVL_DIMMED : LVL_NORMAL;
                if (lvl_measured == LVL_CRITICAL) begin
                    if (critical_since == 0) begin
                        critical_since = it.now_ms;
                    end
                end else begin
                    critical_since = '0;
                end
                if (lvl_measured > lvl_applied) begin
                    recover_since = '0;
                    change_level(lvl_measured, it.ramp_hold);
                end else if (lvl_measured < lvl_applied) begin
                    if (recover_since == 0) begin
                        recover_since = it.now_ms;
                    end else if ((it.now_ms - recover_since) >=
                                 {16'd0, regs.recovery_confirm}) begin
                        change_level(t_level'(lvl_applied - 2'd1), it.ramp_hold);
                        recover_since = it.now_ms;
                    end
                end else begin
                    recover_since = '0;
                end
            end
            if (low_mode && lvl_measured == LVL_CRITICAL && critical_since != 0 &&
                (it.now_ms - critical_since) >= {16'd0, regs.critical_stop_delay}) begin
                sleep = 1'b1;
            end
        end
        r.brightness      = duty;
        r.supply_level    = lvl_applied;
        r.low_battery     = low_mode;
        r.enter_low_event = ev_enter;
        r.leave_low_event = ev_leave;
        r.sleep_request   = sleep;
        return r;
    endfunction

    function automatic string result_text(t_result r);
        return $sformatf("duty %0d level %0d low %b enter %b leave %b sleep %b",
                         r.brightness, r.supply_level, r.low_battery,
                         r.enter_low_event, r.leave_low_event, r.sleep_request);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_item   tick;
        if (!i_rst_n) begin
            clear_model();
            expected_results.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_INTERVAL:     regs.sample_interval     = i_cfg_data;
                    CFG_RECOVERY_CONFIRM:    regs.recovery_confirm    = i_cfg_data;
                    CFG_CRITICAL_STOP_DELAY: regs.critical_stop_delay = i_cfg_data;
                    CFG_RAMP_INTERVAL:       regs.ramp_interval       = i_cfg_data[7:0];
                    CFG_RAMP_STEP:           regs.ramp_step           = i_cfg_data[7:0];
                    CFG_LEVEL_NORMAL:        regs.level_normal        = i_cfg_data[7:0];
                    CFG_LEVEL_DIMMED:        regs.level_dimmed        = i_cfg_data[7:0];
                    CFG_LEVEL_CRITICAL:      regs.level_critical      = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.brightness      = i_out.brightness;
                got.supply_level    = i_out.supply_level;
                got.low_battery     = i_out.low_battery;
                got.enter_low_event = i_out.enter_low_event;
                got.leave_low_event = i_out.leave_low_event;
                got.sleep_request   = i_out.sleep_request;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with no tick pending: %s",
                                 $time, result_text(got));
                    end
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.brightness      !== want.brightness      ||
                        got.supply_level    !== want.supply_level    ||
                        got.low_battery     !== want.low_battery     ||
                        got.enter_low_event !== want.enter_low_event ||
                        got.leave_low_event !== want.leave_low_event ||
                        got.sleep_request   !== want.sleep_request) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch, expected %s", $time, result_text(want));
                            $display("%0t:           actual   %s", $time, result_text(got));
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                tick.now_ms          = i_in.now_ms;
                tick.below_dimmed    = i_in.below_dimmed;
                tick.below_critical  = i_in.below_critical;
                tick.ramp_hold       = i_in.ramp_hold;
                tick.governor_enable = i_in.governor_enable;
                expected_results.push_back(govern_tick(tick));
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

@@ dv/brownout_backlight_governor_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench top of the brownout backlight governor: stimulus, back pressure and verdict.
module brownout_backlight_governor_unit_test;
    import bbg_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bbg_in_if  tick_ch ();
    bbg_out_if result_ch ();

    int          pending;
    int          mismatches;
    int          checked;
    int          ticks_sent;
    int          settings_used;
    int          rx_hold_len;
    logic        calm;
    logic [31:0] clock_ms;
    int          ms_step_max;
    int          supply_len_max;
    int          supply_mode;
    int          supply_left;
    logic [15:0] reg_plan [16];

    brownout_backlight_governor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (result_ch)
    );

    bbg_result_compare u_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (tick_ch),
        .i_out        (result_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_tick(input logic [31:0] now, input logic bdim, input logic bcrit,
                             input logic hold, input logic en);
        if (!calm && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.now_ms          <= now;
        tick_ch.below_dimmed    <= bdim;
        tick_ch.below_critical  <= bcrit;
        tick_ch.ramp_hold       <= hold;
        tick_ch.governor_enable <= en;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs();
        logic [7:0]           junk;
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < 8; i++) begin
            idx  = CFG_IDX_W'(i);
            junk = 8'($urandom_range(0, 255));
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= (idx < CFG_RAMP_INTERVAL) ? reg_plan[idx] :
                                                      {junk, reg_plan[idx][7:0]};
            @(posedge i_clk);
        end
        i_cfg_idx  <= CFG_IDX_W'($urandom_range(8, 15));
        i_cfg_data <= CFG_DATA_W'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_tick();
        int   pick;
        logic bdim;
        logic bcrit;
        pick = $urandom_range(0, 99);
        if (pick == 0) begin
            clock_ms = $urandom;
        end else if (pick == 1) begin
            clock_ms = '0;
        end else if (pick > 3) begin
            clock_ms = clock_ms + $urandom_range(1, ms_step_max);
        end
        if (supply_left == 0) begin
            supply_mode = $urandom_range(0, 2);
            supply_left = $urandom_range(1, supply_len_max);
        end
        supply_left--;
        case (supply_mode)
            0:       begin bdim = 1'b0; bcrit = 1'b0; end
            1:       begin bdim = 1'b1; bcrit = 1'b0; end
            default: begin bdim = 1'($urandom_range(0, 1)); bcrit = 1'b1; end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            bdim  = 1'($urandom_range(0, 1));
            bcrit = 1'($urandom_range(0, 1));
        end
        send_tick(clock_ms, bdim, bcrit, $urandom_range(0, 6) == 0,
                  $urandom_range(0, 11) != 0);
    endtask

    task automatic run_ticks(input int count);
        for (int n = 0; n < count; n++) begin
            random_tick();
        end
    endtask

    task automatic start_phase(input int step_max, input int len_max);
        ms_step_max    = step_max;
        supply_len_max = len_max;
        supply_left    = 0;
        if ($urandom_range(0, 3) == 0) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        end else begin
            clock_ms = $urandom;
        end
    endtask

    task automatic plan_random_regs();
        reg_plan[CFG_SAMPLE_INTERVAL]     = 16'($urandom_range(1, 20));
        reg_plan[CFG_RECOVERY_CONFIRM]    = 16'($urandom_range(1, 80));
        reg_plan[CFG_CRITICAL_STOP_DELAY] = 16'($urandom_range(1, 80));
        reg_plan[CFG_RAMP_INTERVAL]       = 16'($urandom_range(0, 8));
        reg_plan[CFG_RAMP_STEP]           = ($urandom_range(0, 5) == 0) ? 16'd0 :
                                            16'($urandom_range(1, 255));
        reg_plan[CFG_LEVEL_NORMAL]        = 16'($urandom_range(0, 255));
        reg_plan[CFG_LEVEL_DIMMED]        = 16'($urandom_range(0, 255));
        reg_plan[CFG_LEVEL_CRITICAL]      = 16'($urandom_range(0, 255));
    endtask

    initial begin
        #5_000_000;
        $display("brownout_backlight_governor_unit_test: errors");
        $finish;
    end

    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                result_ch.ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                result_ch.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        calm          = 1'b0;
        rx_hold_len   = 0;
        ticks_sent    = 0;
        settings_used = 1;
        supply_left   = 0;
        supply_mode   = 0;
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= '0;
        i_cfg_data              <= '0;
        tick_ch.valid           <= 1'b0;
        tick_ch.now_ms          <= '0;
        tick_ch.below_dimmed    <= 1'b0;
        tick_ch.below_critical  <= 1'b0;
        tick_ch.ramp_hold       <= 1'b0;
        tick_ch.governor_enable <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(32'd0,         1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd100,       1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(32'd5100,      1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(32'd5200,      1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(32'd5300,      1'b1, 1'b1, 1'b0, 1'b1);
        send_tick(32'd5400,      1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(32'd10400,     1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(32'd10500,     1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd15400,     1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd15420,     1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd15440,     1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(32'hFFFF_FF9C, 1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(32'h0000_0064, 1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(32'h0000_0063, 1'b0, 1'b0, 1'b0, 1'b1);

        start_phase(400, 60);
        run_ticks(150);
        wait_drained();

        reg_plan[CFG_SAMPLE_INTERVAL]     = 16'd0;
        reg_plan[CFG_RECOVERY_CONFIRM]    = 16'd0;
        reg_plan[CFG_CRITICAL_STOP_DELAY] = 16'd0;
        reg_plan[CFG_RAMP_INTERVAL]       = 16'd0;
        reg_plan[CFG_RAMP_STEP]           = 16'd0;
        reg_plan[CFG_LEVEL_NORMAL]        = 16'd0;
        reg_plan[CFG_LEVEL_DIMMED]        = 16'd255;
        reg_plan[CFG_LEVEL_CRITICAL]      = 16'd0;
        program_regs();
        start_phase(3, 30);
        run_ticks(200);
        wait_drained();

        reg_plan[CFG_SAMPLE_INTERVAL]     = 16'd1;
        reg_plan[CFG_RECOVERY_CONFIRM]    = 16'd1;
        reg_plan[CFG_CRITICAL_STOP_DELAY] = 16'd1;
        reg_plan[CFG_RAMP_INTERVAL]       = 16'd1;
        reg_plan[CFG_RAMP_STEP]           = 16'd1;
        reg_plan[CFG_LEVEL_NORMAL]        = 16'd255;
        reg_plan[CFG_LEVEL_DIMMED]        = 16'd128;
        reg_plan[CFG_LEVEL_CRITICAL]      = 16'd0;
        program_regs();
        start_phase(2, 30);
        run_ticks(200);
        wait_drained();

        reg_plan[CFG_SAMPLE_INTERVAL]     = 16'hFFFF;
        reg_plan[CFG_RECOVERY_CONFIRM]    = 16'hFFFF;
        reg_plan[CFG_CRITICAL_STOP_DELAY] = 16'hFFFF;
        reg_plan[CFG_RAMP_INTERVAL]       = 16'd255;
        reg_plan[CFG_RAMP_STEP]           = 16'd255;
        reg_plan[CFG_LEVEL_NORMAL]        = 16'd255;
        reg_plan[CFG_LEVEL_DIMMED]        = 16'd0;
        reg_plan[CFG_LEVEL_CRITICAL]      = 16'd255;
        program_regs();
        start_phase(30000, 30);
        run_ticks(150);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            plan_random_regs();
            program_regs();
            start_phase(6, 40);
            if (p == 4) begin
                calm = 1'b1;
            end
            run_ticks(60);
            if (p == 0) begin
                rx_hold_len = 300;
            end else if (p == 1) begin
                wait_drained();
            end
            run_ticks(120);
            wait_drained();
        end

        $display("Sent %0d ticks and checked %0d results over %0d register settings,",
                 ticks_sent, checked, settings_used);
        $display("with zero and full-scale intervals, wrapped time and a long output stall.");
        if (mismatches == 0) begin
            $display("brownout_backlight_governor_unit_test: clean");
        end else begin
            $display("brownout_backlight_governor_unit_test: errors");
        end
        $finish;
    end

endmodule
